// ----- rtl/elfc_pkg.sv -----
// types and constants shared by the ecef / local frame converter
// no dependencies
package elfc_pkg;

    localparam int COORD_W = 36;
    localparam int TRIG_W  = 32;
    localparam int CFG_W   = 36;
    localparam int Q_FRAC  = 30;
    // difference or negated coordinate needs one bit more than a coordinate
    localparam int VEC_W   = COORD_W + 1;
    localparam int LO_W    = 18;
    localparam int HI_W    = VEC_W - LO_W;
    localparam int PROD_W  = TRIG_W + LO_W + 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int RND_W   = 40;
    localparam int SAT_W   = RND_W + 2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [TRIG_W-1:0]  t_trig;
    typedef logic signed [VEC_W-1:0]   t_vec;
    typedef logic        [LO_W-1:0]    t_lo;
    typedef logic signed [HI_W-1:0]    t_hi;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [RND_W-1:0]   t_rnd;
    typedef logic signed [SAT_W-1:0]   t_sat;
    typedef logic        [2:0]         t_cfg_idx;
    typedef logic        [1:0]         t_frame;

    // rows east, north, up; columns x, y, z
    typedef t_trig t_mat [3][3];

    typedef struct packed {
        t_trig sin_lat;
        t_trig cos_lat;
        t_trig sin_lon;
        t_trig cos_lon;
    } t_trig_cfg;

    localparam t_trig ONE_Q30 = t_trig'(64'sd1 <<< Q_FRAC);

    localparam t_cfg_idx CFG_SIN_LAT = 3'd0;
    localparam t_cfg_idx CFG_COS_LAT = 3'd1;
    localparam t_cfg_idx CFG_SIN_LON = 3'd2;
    localparam t_cfg_idx CFG_COS_LON = 3'd3;
    localparam t_cfg_idx CFG_REF_X   = 3'd4;
    localparam t_cfg_idx CFG_REF_Y   = 3'd5;
    localparam t_cfg_idx CFG_REF_Z   = 3'd6;
    localparam t_cfg_idx CFG_FRAME   = 3'd7;

    localparam t_frame FRAME_ENU = 2'd0;
    localparam t_frame FRAME_NED = 2'd1;
    localparam t_frame FRAME_NWU = 2'd2;

    localparam logic OP_TO_LOCAL = 1'b0;
    localparam logic OP_TO_ECEF  = 1'b1;

endpackage

// ----- rtl/elfc_in_if.sv -----
// input channel of the converter: operation and one point
// depends on elfc_pkg
interface elfc_in_if import elfc_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   operation;
    t_coord coord_x;
    t_coord coord_y;
    t_coord coord_z;

    modport source (output valid, output operation, output coord_x, output coord_y,
                    output coord_z, input ready);
    modport sink   (input valid, input operation, input coord_x, input coord_y,
                    input coord_z, output ready);
endinterface

// ----- rtl/elfc_out_if.sv -----
// output channel of the converter: one converted point
// depends on elfc_pkg
interface elfc_out_if import elfc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord out_x;
    t_coord out_y;
    t_coord out_z;

    modport source (output valid, output out_x, output out_y, output out_z, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

// ----- rtl/elfc_rot_mat.sv -----
// rotation matrix builder: clamps the trig registers and forms the east,
// north and up rows in Q1.30; depends on elfc_pkg
module elfc_rot_mat import elfc_pkg::*; (
    input  logic      i_clk,
    input  t_trig_cfg i_trig,
    output t_mat      o_mat
);

    function automatic t_trig clamp_trig(t_trig v);
        if (v > ONE_Q30) begin
            return ONE_Q30;
        end else if (v < -ONE_Q30) begin
            return -ONE_Q30;
        end
        return v;
    endfunction

    // round half up, floor of the shifted product
    function automatic t_trig q30_mul(t_trig a, t_trig b);
        logic signed [2*TRIG_W-1:0] p;
        p = a * b + ((2*TRIG_W)'(64'sd1) <<< (Q_FRAC - 1));
        return p[Q_FRAC+TRIG_W-1:Q_FRAC];
    endfunction

    t_trig slat, clat, slon, clon;
    t_mat  r_mat;

    always_comb begin
        slat = clamp_trig(i_trig.sin_lat);
        clat = clamp_trig(i_trig.cos_lat);
        slon = clamp_trig(i_trig.sin_lon);
        clon = clamp_trig(i_trig.cos_lon);
    end

    always_ff @(posedge i_clk) begin
        r_mat[0][0] <= -slon;
        r_mat[0][1] <= clon;
        r_mat[0][2] <= '0;
        r_mat[1][0] <= -q30_mul(slat, clon);
        r_mat[1][1] <= -q30_mul(slat, slon);
        r_mat[1][2] <= clat;
        r_mat[2][0] <= q30_mul(clat, clon);
        r_mat[2][1] <= q30_mul(clat, slon);
        r_mat[2][2] <= slat;
    end

    assign o_mat = r_mat;

endmodule

// ----- rtl/ecef_local_frame_convert_top.sv -----
// ECEF <-> local tangent plane converter (ENU, NED or NWU axes), top level.
// Takes one point per cycle while the output is not stalled. Each result
// passes through the input register, operand and matrix selection, split
// 32x19 products, row sums, rounding, then axis mapping or reference add
// with saturation in the output register. The pipeline has six stages;
// each stage holds its item while the stage after it is full and stalled,
// so bubbles close up under back-pressure. The rotation matrix is
// registered from the trig registers, so a configuration write reaches it
// through the trig register and then the matrix register.
// depends on elfc_pkg, elfc_in_if, elfc_out_if, elfc_rot_mat
module ecef_local_frame_convert_top import elfc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  t_cfg_idx        i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    elfc_in_if.sink         i_in,
    elfc_out_if.source      o_out
);

    localparam int NSTAGE = 6;

    function automatic t_coord sat_coord(t_sat v);
        if (v[SAT_W-1:COORD_W-1] == '0 || v[SAT_W-1:COORD_W-1] == '1) begin
            return v[COORD_W-1:0];
        end else if (v[SAT_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        return {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    localparam t_sum RND_HALF = t_sum'(64'sd1 <<< (Q_FRAC - 1));

    // configuration registers
    t_trig_cfg r_trig;
    t_coord    r_ref [3];
    t_frame    r_frame;
    t_mat      mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig.sin_lat <= '0;
            r_trig.cos_lat <= ONE_Q30;
            r_trig.sin_lon <= '0;
            r_trig.cos_lon <= ONE_Q30;
            r_ref[0]       <= '0;
            r_ref[1]       <= '0;
            r_ref[2]       <= '0;
            r_frame        <= FRAME_ENU;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIN_LAT: r_trig.sin_lat <= i_cfg_data[TRIG_W-1:0];
                CFG_COS_LAT: r_trig.cos_lat <= i_cfg_data[TRIG_W-1:0];
                CFG_SIN_LON: r_trig.sin_lon <= i_cfg_data[TRIG_W-1:0];
                CFG_COS_LON: r_trig.cos_lon <= i_cfg_data[TRIG_W-1:0];
                CFG_REF_X:   r_ref[0]       <= i_cfg_data[COORD_W-1:0];
                CFG_REF_Y:   r_ref[1]       <= i_cfg_data[COORD_W-1:0];
                CFG_REF_Z:   r_ref[2]       <= i_cfg_data[COORD_W-1:0];
                CFG_FRAME:   r_frame        <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    elfc_rot_mat u_rot_mat (
        .i_clk  (i_clk),
        .i_trig (r_trig),
        .o_mat  (mat)
    );

    // stage control: a stage takes a new item when empty or when it moves on
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE:0]   adv;

    always_comb begin
        adv[NSTAGE] = o_out.ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready = adv[0];

    // stage a: input register
    logic   r_a_op;
    t_coord r_a_c [3];

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_a_op   <= i_in.operation;
            r_a_c[0] <= i_in.coord_x;
            r_a_c[1] <= i_in.coord_y;
            r_a_c[2] <= i_in.coord_z;
        end
    end

    // stage b: operand vector and matrix orientation
    t_vec  vec [3];
    t_vec  loc [3];
    t_lo   r_b_vl [3];
    t_hi   r_b_vh [3];
    t_mat  r_b_m;
    logic  r_b_op;

    always_comb begin
        case (r_frame)
            FRAME_NED: begin
                loc[0] = t_vec'(r_a_c[1]);
                loc[1] = t_vec'(r_a_c[0]);
                loc[2] = -t_vec'(r_a_c[2]);
            end
            FRAME_NWU: begin
                loc[0] = -t_vec'(r_a_c[1]);
                loc[1] = t_vec'(r_a_c[0]);
                loc[2] = t_vec'(r_a_c[2]);
            end
            default: begin
                loc[0] = t_vec'(r_a_c[0]);
                loc[1] = t_vec'(r_a_c[1]);
                loc[2] = t_vec'(r_a_c[2]);
            end
        endcase
        for (int j = 0; j < 3; j++) begin
            if (r_a_op == OP_TO_ECEF) begin
                vec[j] = loc[j];
            end else begin
                vec[j] = t_vec'(r_a_c[j]) - t_vec'(r_ref[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_b_op <= r_a_op;
            for (int j = 0; j < 3; j++) begin
                r_b_vl[j] <= vec[j][LO_W-1:0];
                r_b_vh[j] <= vec[j][VEC_W-1:LO_W];
            end
            // going back uses the transposed rotation
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_b_m[i][j] <= (r_a_op == OP_TO_ECEF) ? mat[j][i] : mat[i][j];
                end
            end
        end
    end

    // stage c: split products, low part unsigned
    t_prod r_c_pl [3][3];
    t_prod r_c_ph [3][3];
    logic  r_c_op;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_c_op <= r_b_op;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_c_pl[i][j] <= r_b_m[i][j] * $signed({1'b0, r_b_vl[j]});
                    r_c_ph[i][j] <= r_b_m[i][j] * r_b_vh[j];
                end
            end
        end
    end

    // stage d: row sums with the rounding half folded into the low sum
    t_sum r_d_lo [3];
    t_sum r_d_hi [3];
    logic r_d_op;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_d_op <= r_c_op;
            for (int i = 0; i < 3; i++) begin
                r_d_lo[i] <= t_sum'(r_c_pl[i][0]) + t_sum'(r_c_pl[i][1])
                           + t_sum'(r_c_pl[i][2]) + RND_HALF;
                r_d_hi[i] <= t_sum'(r_c_ph[i][0]) + t_sum'(r_c_ph[i][1])
                           + t_sum'(r_c_ph[i][2]);
            end
        end
    end

    // stage e: floor of the full sum over 2^30
    t_sum comb_sum [3];
    t_rnd r_e_r [3];
    logic r_e_op;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            comb_sum[i] = r_d_hi[i] + (r_d_lo[i] >>> LO_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_e_op <= r_d_op;
            for (int i = 0; i < 3; i++) begin
                r_e_r[i] <= comb_sum[i][RND_W+Q_FRAC-LO_W-1:Q_FRAC-LO_W];
            end
        end
    end

    // stage f: axis mapping or reference add, then saturation
    t_sat   fin [3];
    t_coord r_f_out [3];

    always_comb begin
        if (r_e_op == OP_TO_ECEF) begin
            for (int i = 0; i < 3; i++) begin
                fin[i] = t_sat'(r_e_r[i]) + t_sat'(r_ref[i]);
            end
        end else begin
            case (r_frame)
                FRAME_NED: begin
                    fin[0] = t_sat'(r_e_r[1]);
                    fin[1] = t_sat'(r_e_r[0]);
                    fin[2] = -t_sat'(r_e_r[2]);
                end
                FRAME_NWU: begin
                    fin[0] = t_sat'(r_e_r[1]);
                    fin[1] = -t_sat'(r_e_r[0]);
                    fin[2] = t_sat'(r_e_r[2]);
                end
                default: begin
                    fin[0] = t_sat'(r_e_r[0]);
                    fin[1] = t_sat'(r_e_r[1]);
                    fin[2] = t_sat'(r_e_r[2]);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            for (int i = 0; i < 3; i++) begin
                r_f_out[i] <= sat_coord(fin[i]);
            end
        end
    end

    assign o_out.valid = r_vld[NSTAGE-1];
    assign o_out.out_x = r_f_out[0];
    assign o_out.out_y = r_f_out[1];
    assign o_out.out_z = r_f_out[2];

endmodule
